// ----- rtl/homogeneous_vertex_transform_unit_assert.svh -----
// assertion macros for the vertex transform unit
`ifndef HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_ASSERT_SVH
`define HOMOGENEOUS_VERTEX_TRANSFORM_UNIT_ASSERT_SVH
// a property that must hold after an antecedent, checked outside reset
`define HVT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hvt check failed");
// a property that must hold in the next cycle
`define HVT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hvt check failed");
`endif

// ----- rtl/hvt_pkg.sv -----
// ----------------------------------------------------------------------------
// hvt_pkg
// types and constants of the homogeneous vertex transform unit
// ----------------------------------------------------------------------------
package hvt_pkg;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_XFORM = 1'b1;
  localparam logic [31:0] FIX_ONE = 32'h0001_0000;

  typedef struct packed {
    logic               cmd;
    logic [1:0]         row;
    logic [1:0]         col;
    logic signed [31:0] element;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
  } hvt_in_t;

  typedef struct packed {
    logic signed [15:0] out_x;
    logic signed [15:0] out_y;
    logic signed [15:0] out_z;
    logic               divided;
  } hvt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_OUT,
    ST_CLEAR
  } hvt_state_t;

  // divider handshake
  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
  } hvt_div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quo;
  } hvt_div_rsp_t;

endpackage

// ----- rtl/hvt_ram.sv -----
// ----------------------------------------------------------------------------
// hvt_ram
// generic single port ram, registered read
// ----------------------------------------------------------------------------
module hvt_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

// ----- rtl/hvt_div.sv -----
// ----------------------------------------------------------------------------
// hvt_div
// signed 32-bit restoring divider, truncating, one quotient bit per cycle
// ----------------------------------------------------------------------------
module hvt_div
  import hvt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  hvt_div_req_t req,
  output hvt_div_rsp_t rsp
);
  logic        busy_r, busy_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [31:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] den_r, den_nxt;
  logic        neg_r, neg_nxt;
  logic        done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[31]} - {1'b0, den_r};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = req.num[31] ? (32'd0 - req.num) : req.num;
      den_nxt  = req.den[31] ? (32'd0 - req.den) : req.den;
      neg_nxt  = req.num[31] ^ req.den[31];
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_nxt = trial[31:0];
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[30:0], quo_r[31]};
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r <= cnt_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quo  = neg_r ? (32'd0 - quo_r) : quo_r;
endmodule

// ----- rtl/homogeneous_vertex_transform_unit.sv -----
// ----------------------------------------------------------------------------
// homogeneous_vertex_transform_unit
// 4x4 16.16 matrix times integer vertex, with perspective divide by w
// ----------------------------------------------------------------------------
//  channel | ports            | carries
//  input   | in_valid/ready   | write element or transform vertex request
//  output  | out_valid/ready  | transformed x, y, z and divided flag
//
//  a write request is taken in idle and stays there; a transform runs a
//  multiply-accumulate (16 matrix reads through the one ram port, one
//  multiply each), then takes the integer parts when w is 0 or 1.0 or else
//  divides x, y and z by w in turn, then loads the output register
//  after reset a clearing pass zeroes all 16 matrix ram words; no request
//  is taken then. a finished result sits in the output register; the next
//  request is taken while it waits, but a new result waits for its slot
// ----------------------------------------------------------------------------
module homogeneous_vertex_transform_unit
  import hvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  hvt_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output hvt_out_t out_data
);
  hvt_state_t  state_r, state_nxt;
  logic [4:0]  idx_r, idx_nxt;     // mac step / clear address / div lane
  logic        rd_pend_r;          // ram read issued last cycle
  logic [1:0]  rd_col_r;
  logic [1:0]  rd_row_r;
  logic        last_rd_r;
  logic [31:0] acc_r [4];
  logic [31:0] prod_r;
  logic        prod_vld_r;
  logic [1:0]  prod_row_r;
  logic        prod_last_r;
  logic signed [15:0] vx_r, vy_r, vz_r;
  logic [15:0] q_r [3];
  logic        dvd_r;
  logic        ov_r;
  hvt_out_t    od_r;

  logic        we;
  logic [3:0]  addr;
  logic [31:0] wdata, rdata;
  hvt_div_req_t dreq;
  hvt_div_rsp_t drsp;
  logic [31:0] w;
  logic        use_div;
  logic        start_issued_r;
  logic [31:0] vsel;

  hvt_ram #(.Width(32), .Depth(16)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  hvt_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign w       = acc_r[3];
  assign use_div = (w != 32'd0) && (w != FIX_ONE);
  assign in_ready = (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (idx_r == 5'd15) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid && in_data.cmd == CMD_XFORM) state_nxt = ST_MAC;
      ST_MAC:   if (prod_vld_r && prod_last_r) state_nxt = ST_DIV;
      ST_DIV: begin
        if (!use_div) state_nxt = ST_OUT;
        else if (drsp.done && idx_r == 5'd2) state_nxt = ST_OUT;
      end
      ST_OUT:   if (!ov_r || out_ready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // ram port and sequencing
  always_comb begin
    we      = 1'b0;
    addr    = {in_data.row, in_data.col};
    wdata   = in_data.element;
    idx_nxt = idx_r;
    dreq.start = 1'b0;
    dreq.num   = acc_r[idx_r[1:0]];
    dreq.den   = w;
    unique case (state_r)
      ST_CLEAR: begin
        we = 1'b1; addr = idx_r[3:0]; wdata = '0; idx_nxt = idx_r + 5'd1;
      end
      ST_IDLE: begin
        we = in_valid && in_data.cmd == CMD_WRITE;
        idx_nxt = '0;
      end
      ST_MAC: begin
        addr = idx_r[3:0];
        if (idx_r < 5'd16) idx_nxt = idx_r + 5'd1;
        if (prod_vld_r && prod_last_r) idx_nxt = '0;
      end
      ST_DIV: begin
        if (use_div && !start_issued_r) dreq.start = 1'b1;
        if (drsp.done) idx_nxt = idx_r + 5'd1;
      end
      ST_OUT: idx_nxt = '0;
      default: ;
    endcase
  end

  always_comb begin
    unique case (rd_col_r)
      2'd0: vsel = {{16{vx_r[15]}}, vx_r};
      2'd1: vsel = {{16{vy_r[15]}}, vy_r};
      2'd2: vsel = {{16{vz_r[15]}}, vz_r};
      default: vsel = 32'd1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_CLEAR;
      idx_r          <= '0;
      rd_pend_r      <= 1'b0;
      prod_vld_r     <= 1'b0;
      ov_r           <= 1'b0;
      start_issued_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      idx_r     <= idx_nxt;
      rd_pend_r <= (state_r == ST_MAC) && (idx_r < 5'd16);
      prod_vld_r <= rd_pend_r;
      if (state_r != ST_DIV) start_issued_r <= 1'b0;
      else if (drsp.done) start_issued_r <= 1'b0;
      else if (dreq.start) start_issued_r <= 1'b1;
      // a new result refills the slot in the cycle the old one leaves
      if (state_r == ST_OUT && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_valid && out_ready) ov_r <= 1'b0;
    end
    rd_col_r  <= idx_r[1:0];
    rd_row_r  <= idx_r[3:2];
    last_rd_r <= (idx_r == 5'd15);
    // registered product, then accumulate
    prod_r      <= rdata * vsel;
    prod_row_r  <= rd_row_r;
    prod_last_r <= last_rd_r;
    if (state_r == ST_IDLE) begin
      vx_r <= in_data.vx; vy_r <= in_data.vy; vz_r <= in_data.vz;
      for (int i = 0; i < 4; i++) acc_r[i] <= '0;
    end else if (prod_vld_r) begin
      acc_r[prod_row_r] <= acc_r[prod_row_r] + prod_r;
    end
    if (state_r == ST_DIV) begin
      dvd_r <= use_div;
      if (!use_div) begin
        for (int i = 0; i < 3; i++) q_r[i] <= acc_r[i][31:16];
      end else if (drsp.done) begin
        q_r[idx_r[1:0]] <= drsp.quo[15:0];
      end
    end
    if (state_r == ST_OUT && (!ov_r || out_ready)) begin
      od_r.out_x <= q_r[0]; od_r.out_y <= q_r[1]; od_r.out_z <= q_r[2];
      od_r.divided <= dvd_r;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule

// ----- rtl/hvt_checker.sv -----
// ----------------------------------------------------------------------------
// hvt_checker
// port-level checks of the vertex transform unit
// ----------------------------------------------------------------------------
`include "homogeneous_vertex_transform_unit_assert.svh"
module hvt_checker
  import hvt_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input hvt_in_t  in_data,
  input logic     out_valid,
  input logic     out_ready,
  input hvt_out_t out_data
);
  `HVT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  `HVT_ASSERT_NEXT(a_busy_after_xform, clk, rst_n, in_valid && in_ready && in_data.cmd == CMD_XFORM, !in_ready)
  `HVT_ASSERT_NEXT(a_write_no_out, clk, rst_n, in_valid && in_ready && in_data.cmd == CMD_WRITE && !out_valid, !out_valid)
endmodule

bind homogeneous_vertex_transform_unit hvt_checker u_hvt_checker (.*);

// ----- tb/sv/hvt_scoreboard.sv -----
// ----------------------------------------------------------------------------
// hvt_scoreboard
// watches both channels, keeps a copy of the matrix and compares each result
// ----------------------------------------------------------------------------
module hvt_scoreboard
  import hvt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  hvt_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  hvt_out_t out_data,
  output int       fail_count,
  output int       pending
);

  logic [31:0] mat_copy [16];
  hvt_out_t    vertex_q [$];

  // signed divide, truncating toward zero, wrapping on overflow
  function automatic logic [31:0] div_trunc(logic [31:0] n, logic [31:0] d);
    logic [31:0] un, ud, q;
    un = n[31] ? -n : n;
    ud = d[31] ? -d : d;
    q  = un / ud;
    return (n[31] != d[31]) ? -q : q;
  endfunction

  function automatic hvt_out_t project_vertex(hvt_in_t req);
    logic [31:0] v4 [4];
    logic [31:0] acc [4];
    hvt_out_t    res;
    v4[0] = {{16{req.vx[15]}}, req.vx};
    v4[1] = {{16{req.vy[15]}}, req.vy};
    v4[2] = {{16{req.vz[15]}}, req.vz};
    v4[3] = 32'd1;
    for (int i = 0; i < 4; i++) begin
      acc[i] = '0;
      for (int j = 0; j < 4; j++) acc[i] += v4[j] * mat_copy[i*4+j];
    end
    if (acc[3] == 32'd0 || acc[3] == FIX_ONE) begin
      res.out_x = acc[0][31:16];
      res.out_y = acc[1][31:16];
      res.out_z = acc[2][31:16];
      res.divided = 1'b0;
    end else begin
      res.out_x = 16'(div_trunc(acc[0], acc[3]));
      res.out_y = 16'(div_trunc(acc[1], acc[3]));
      res.out_z = 16'(div_trunc(acc[2], acc[3]));
      res.divided = 1'b1;
    end
    return res;
  endfunction

  task automatic report(string what, hvt_out_t got, hvt_out_t want);
    $display("mismatch %s: got x %h y %h z %h d %b want x %h y %h z %h d %b", what,
             got.out_x, got.out_y, got.out_z, got.divided,
             want.out_x, want.out_y, want.out_z, want.divided);
    fail_count++;
  endtask

  assign pending = vertex_q.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    hvt_out_t want;
    if (!rst_n) begin
      foreach (mat_copy[i]) mat_copy[i] = '0;
      vertex_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (vertex_q.size() == 0) begin
          report("unexpected result", out_data, '0);
        end else begin
          want = vertex_q.pop_front();
          if (out_data !== want) report("result", out_data, want);
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.cmd == CMD_WRITE) mat_copy[{in_data.row, in_data.col}] = in_data.element;
        else vertex_q.push_back(project_vertex(in_data));
      end
    end
  end

endmodule

// ----- tb/sv/tb_homogeneous_vertex_transform_unit.sv -----
// ----------------------------------------------------------------------------
// tb_homogeneous_vertex_transform_unit
// drives matrix writes and vertex transforms with random gaps and stalls;
// the scoreboard predicts each projected vertex and counts mismatches
// ----------------------------------------------------------------------------
module tb_homogeneous_vertex_transform_unit;
  import hvt_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int IN_W = $bits(hvt_in_t);

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  hvt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  hvt_out_t out_data;
  int       fail_count;
  int       pending;
  bit       sink_hold = 1'b0;   // long receiver hold-off
  bit       sink_free = 1'b1;   // allow random stalls
  int       quiet_cycles = 0;

  always #5 clk = ~clk;

  homogeneous_vertex_transform_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  hvt_scoreboard checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // send one request, hold valid until taken, then a random gap
  task automatic send_request(hvt_in_t req, bit no_gap = 1'b0);
    int gap;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    gap = no_gap ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_element(int r, int c, logic [31:0] val);
    hvt_in_t req;
    req = hvt_in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
    req.cmd = CMD_WRITE;
    req.row = 2'(r);
    req.col = 2'(c);
    req.element = val;
    send_request(req);
  endtask

  task automatic transform_vertex(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                  bit no_gap = 1'b0);
    hvt_in_t req;
    req = hvt_in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
    req.cmd = CMD_XFORM;
    req.vx = x;
    req.vy = y;
    req.vz = z;
    send_request(req, no_gap);
  endtask

  // a mix of element values: small 16.16, full range, and corner words
  function automatic logic [31:0] pick_element();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 8192)) - 4096) <<< 8;
      2: return FIX_ONE;
      3: return 32'h8000_0000;
      4: return 32'h7fff_ffff;
      default: return 32'($signed($urandom_range(0, 400)) - 200);
    endcase
  endfunction

  // w row: often exactly 0 or 1.0 to hit the shift path, else small values or any element
  function automatic logic [31:0] pick_w_element(bit last);
    case ($urandom_range(0, 4))
      0: return '0;
      1: return last ? FIX_ONE : '0;
      2: return 32'($signed($urandom_range(0, 40)) - 20);
      default: return pick_element();
    endcase
  endfunction

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'($signed($urandom_range(0, 20)) - 10);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      default: return 16'($urandom());
    endcase
  endfunction

  // receiver: random stalls, always ready when stalls are off, or held off entirely during pressure phase
  always @(posedge clk) begin
    int wait_left;
    if (sink_hold) begin
      out_ready <= 1'b0;
    end else if (!sink_free) begin
      out_ready <= 1'b1;
    end else if (out_valid && out_ready) begin
      wait_left = $urandom_range(0, 5);
      if (wait_left != 0) begin
        out_ready <= 1'b0;
        repeat (wait_left) @(posedge clk);
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero matrix, identity, extremes, divide by w cases
    transform_vertex(16'h7fff, 16'h8000, 16'h0001);
    for (int i = 0; i < 4; i++) write_element(i, i, FIX_ONE);
    transform_vertex(16'h7fff, 16'h8000, 16'hffff);
    transform_vertex(16'h0000, 16'h1234, 16'h8000);
    // w = -1 with x = most negative word: quotient wraps
    write_element(0, 3, 32'h8000_0000);
    write_element(0, 0, 32'h0);
    write_element(3, 3, 32'hffff_ffff);
    transform_vertex(16'h0, 16'h0, 16'h0);
    // w from vertex z, divide path with negatives
    write_element(3, 2, 32'h0000_0003);
    write_element(3, 3, 32'h0000_0000);
    write_element(0, 3, 32'h7fff_ffff);
    write_element(1, 0, 32'h8000_0000);
    transform_vertex(16'h0005, 16'hfff9, 16'hfffe);
    transform_vertex(16'h8000, 16'h7fff, 16'h7fff);
    // w = 0 after products wrap
    write_element(3, 0, 32'h0001_0000);
    write_element(3, 1, 32'hffff_0000);
    write_element(3, 2, 32'h0);
    transform_vertex(16'h0007, 16'h0007, 16'h1111);

    // pressure: hold the receiver while requests keep coming
    sink_hold = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        sink_hold = 1'b0;
      end
      begin
        for (int i = 0; i < 8; i++) transform_vertex(pick_coord(), pick_coord(), pick_coord());
        in_valid <= 1'b0;
      end
    join
    drain();

    // random: new matrix phases, each followed by a burst of vertices and stray writes
    for (int phase = 0; phase < 64; phase++) begin
      sink_free = (phase % 7 != 3);  // some phases with no receiver stalls
      for (int k = 0; k < 16; k++) begin
        if ($urandom_range(0, 2) != 0) begin
          if (k >= 12) write_element(3, k - 12, pick_w_element(k == 15));
          else write_element(k / 4, k % 4, pick_element());
        end
      end
      for (int v = 0; v < 18; v++) begin
        if ($urandom_range(0, 9) == 0)
          write_element($urandom(), $urandom(), pick_element());
        else
          transform_vertex(pick_coord(), pick_coord(), pick_coord(), phase % 7 == 5);
      end
      if (phase % 10 == 9) drain();  // sender pauses until all results are in
    end
    sink_free = 1'b1;
    drain();

    if (fail_count == 0 && pending == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

endmodule

// ----- homogeneous_vertex_transform_unit.f -----
+incdir+rtl
rtl/hvt_pkg.sv
rtl/hvt_ram.sv
rtl/hvt_div.sv
rtl/homogeneous_vertex_transform_unit.sv
rtl/hvt_checker.sv
tb/sv/hvt_scoreboard.sv
tb/sv/tb_homogeneous_vertex_transform_unit.sv
